>>> design/amc_pkg.sv
// Shared types and codes for the accumulator machine core.
// Depends on nothing; the core, controller and datapath files import it.
package amc_pkg;

  localparam int PROG_DEPTH_DEF  = 1024;
  localparam int DATA_DEPTH_DEF  = 1024;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [2:0] CMD_PROG    = 3'd0;
  localparam logic [2:0] CMD_DATA    = 3'd1;
  localparam logic [2:0] CMD_STEP    = 3'd2;
  localparam logic [2:0] CMD_READ    = 3'd3;
  localparam logic [2:0] CMD_RESTART = 3'd4;

  localparam logic [3:0] OP_LDA = 4'd0;
  localparam logic [3:0] OP_LDI = 4'd1;
  localparam logic [3:0] OP_STA = 4'd2;
  localparam logic [3:0] OP_STI = 4'd3;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_SUB = 4'd5;
  localparam logic [3:0] OP_JMP = 4'd6;
  localparam logic [3:0] OP_JMZ = 4'd7;
  localparam logic [3:0] OP_JMN = 4'd8;
  localparam logic [3:0] OP_JAL = 4'd9;
  localparam logic [3:0] OP_ALC = 4'd10;
  localparam logic [3:0] OP_DLC = 4'd11;
  localparam logic [3:0] OP_SYS = 4'd12;
  localparam logic [3:0] OP_HLT = 4'd13;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_ADDR  = 3'd1;
  localparam logic [2:0] ERR_STK_OVER  = 3'd2;
  localparam logic [2:0] ERR_STK_EMPTY = 3'd3;
  localparam logic [2:0] ERR_STORE     = 3'd4;
  localparam logic [2:0] ERR_PROG_FULL = 3'd5;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_NUMBER = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_OPER  = 5'b00100,
    ST_IND   = 5'b01000,
    ST_EXEC  = 5'b10000
  } amc_state_t;

  // controller -> datapath
  typedef struct packed {
    logic idle;    // ready for a new word
    logic fetch;   // read program word, read data at latched address
    logic oper;    // read first operand / stack top
    logic ind;     // read indirect operand
    logic commit;  // update state and load result register
  } amc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic accept;    // request word taken this cycle
    logic run;       // step command that will execute an instruction
    logic indirect;  // fetched instruction needs a second data read
    logic out_free;  // result register can be loaded
  } amc_status_t;

endpackage

>>> design/amc_if.sv
// Request and response channel interfaces for the accumulator machine core.
// Depends on nothing.
interface amc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [3:0]  opcode;
  logic [9:0]  operand;
  logic signed [31:0] value;
  logic [9:0]  address;

  modport source (output valid, cmd, opcode, operand, value, address, input ready);
  modport sink   (input valid, cmd, opcode, operand, value, address, output ready);
endinterface

interface amc_rsp_if;
  logic        valid;
  logic        ready;
  logic [10:0] prog_counter;
  logic signed [31:0] accumulator;
  logic        halted;
  logic [1:0]  out_kind;
  logic signed [31:0] out_value;
  logic [2:0]  error;

  modport source (output valid, prog_counter, accumulator, halted, out_kind, out_value, error,
                  input ready);
  modport sink   (input valid, prog_counter, accumulator, halted, out_kind, out_value, error,
                  output ready);
endinterface

>>> design/accumulator_machine_core.sv
// Accumulator machine core: a small random-access machine with program,
// data and return-stack stores, driven one command word at a time. Each
// request word gives exactly one response word. Append, read and restart
// commands pass through the fetch and execute states; a step that executes
// an instruction adds the operand state, and the indirect LDI/STI also the
// indirect state, with any wait in execute for the response register to
// drain. The order is set by the single-port synchronous stores: a state
// for the program fetch and one per dependent data read before writeback.
// The stores need no clearing after reset; only written entries are read.
// Depends on amc_pkg, amc_if, amc_ctrl, amc_dp.
module accumulator_machine_core
  import amc_pkg::*;
#(
  parameter int PROG_DEPTH  = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  amc_req_if.sink   req,
  amc_rsp_if.source rsp
);

  amc_cmd_t    cmd;
  amc_status_t status;

  // sequencer: idle -> fetch -> (operand -> (indirect)) -> execute
  amc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // stores, machine registers and the response register
  amc_dp #(
    .PROG_DEPTH  (PROG_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cmd    (cmd),
    .status (status)
  );

endmodule

>>> design/amc_ctrl.sv
// Sequencing state machine of the accumulator machine core.
// Depends on amc_pkg.
module amc_ctrl
  import amc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  amc_status_t status,
  output amc_cmd_t    cmd
);

  amc_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (status.accept) state_next = ST_FETCH;
      ST_FETCH: state_next = status.run ? ST_OPER : ST_EXEC;
      ST_OPER:  state_next = status.indirect ? ST_IND : ST_EXEC;
      ST_IND:   state_next = ST_EXEC;
      ST_EXEC:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign cmd.idle   = (state == ST_IDLE);
  assign cmd.fetch  = (state == ST_FETCH);
  assign cmd.oper   = (state == ST_OPER);
  assign cmd.ind    = (state == ST_IND);
  assign cmd.commit = (state == ST_EXEC) && status.out_free;

endmodule

>>> design/amc_dp.sv
// Datapath of the accumulator machine core: stores, machine registers,
// instruction execution and the result register. Depends on amc_pkg, amc_if.
module amc_dp
  import amc_pkg::*;
#(
  parameter int PROG_DEPTH  = PROG_DEPTH_DEF,
  parameter int DATA_DEPTH  = DATA_DEPTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  amc_req_if.sink     req,
  amc_rsp_if.source   rsp,
  input  amc_cmd_t    cmd,
  output amc_status_t status
);

  localparam int PAW = $clog2(PROG_DEPTH);
  localparam int PW  = $clog2(PROG_DEPTH + 1);
  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int DLW = $clog2(DATA_DEPTH + 1);
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  logic [13:0]   prog_mem  [PROG_DEPTH];
  logic [31:0]   data_mem  [DATA_DEPTH];
  logic [PW-1:0] stack_mem [STACK_DEPTH];

  // latched request word
  logic [2:0]  cmd_q;
  logic [3:0]  opc_q;
  logic [9:0]  opd_q;
  logic [31:0] val_q;
  logic [9:0]  adr_q;

  // machine state
  logic [PW-1:0]  plen, pc;
  logic [DLW-1:0] dlen;
  logic [SPW-1:0] sp;
  logic [31:0]    acc;
  logic           halt;

  logic [PW-1:0]  plen_next, pc_next;
  logic [DLW-1:0] dlen_next;
  logic [SPW-1:0] sp_next;
  logic [31:0]    acc_next;
  logic           halt_next;

  // memory read registers
  logic [13:0]   prog_q;
  logic [31:0]   dat_q;
  logic [31:0]   word1;
  logic [PW-1:0] stk_q;

  logic rsp_valid;

  logic [3:0]  op;
  logic [9:0]  x;
  logic [31:0] len32, pc32;
  logic        x_ok, w1_ok, adr_ok, tgt_ok, pc_in;
  logic [DAW-1:0] drd_addr;

  logic [2:0]  err;
  logic [1:0]  kind;
  logic [31:0] oval;
  logic           dwe, pwe, swe;
  logic [DAW-1:0] dwa;
  logic [31:0]    dwd;

  assign op     = prog_q[13:10];
  assign x      = prog_q[9:0];
  assign len32  = 32'(dlen);
  assign pc32   = 32'(pc);
  assign x_ok   = {22'b0, x} < len32;
  assign w1_ok  = word1 < len32;
  assign adr_ok = {22'b0, adr_q} < len32;
  assign tgt_ok = !dat_q[31] && (dat_q != 32'd0) && (dat_q <= 32'(PROG_DEPTH));
  assign pc_in  = pc32 < 32'(plen);

  assign req.ready       = cmd.idle;
  assign status.accept   = req.valid && cmd.idle;
  assign status.run      = (cmd_q == CMD_STEP) && !halt && pc_in;
  assign status.indirect = (op == OP_LDI) || (op == OP_STI);
  assign status.out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (status.accept) begin
      cmd_q <= req.cmd;
      opc_q <= req.opcode;
      opd_q <= req.operand;
      val_q <= req.value;
      adr_q <= req.address;
    end
  end

  always_comb begin
    drd_addr = DAW'(adr_q);
    if (cmd.oper) begin
      drd_addr = (op == OP_DLC) ? DAW'(dlen - 1'b1) : DAW'(x);
    end else if (cmd.ind) begin
      drd_addr = dat_q[DAW-1:0];
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (cmd.fetch) prog_q <= prog_mem[pc[PAW-1:0]];
    if (pwe) prog_mem[plen[PAW-1:0]] <= {opc_q, opd_q};
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch || cmd.oper || cmd.ind) dat_q <= data_mem[drd_addr];
    if (dwe) data_mem[dwa] <= dwd;
  end

  always_ff @(posedge clk) begin
    if (cmd.oper) stk_q <= stack_mem[SAW'(sp - 1'b1)];
    if (swe) stack_mem[sp[SAW-1:0]] <= pc;
  end

  always_ff @(posedge clk) begin
    if (cmd.ind) word1 <= dat_q;
  end

  always_comb begin
    pc_next   = pc;
    acc_next  = acc;
    halt_next = halt;
    dlen_next = dlen;
    plen_next = plen;
    sp_next   = sp;
    err  = ERR_NONE;
    kind = KIND_NONE;
    oval = 32'd0;
    dwe  = 1'b0;
    dwa  = DAW'(x);
    dwd  = acc;
    pwe  = 1'b0;
    swe  = 1'b0;
    case (cmd_q)
      CMD_PROG: begin
        if (32'(plen) >= 32'(PROG_DEPTH)) begin
          err = ERR_PROG_FULL;
        end else begin
          pwe       = 1'b1;
          plen_next = plen + 1'b1;
        end
      end
      CMD_DATA: begin
        if (len32 >= 32'(DATA_DEPTH)) begin
          err = ERR_STORE;
        end else begin
          dwe       = 1'b1;
          dwa       = DAW'(dlen);
          dwd       = val_q;
          dlen_next = dlen + 1'b1;
        end
      end
      CMD_STEP: begin
        if (!halt && !pc_in) begin
          halt_next = 1'b1;
        end else if (!halt) begin
          case (op) inside
            OP_LDA, OP_ADD, OP_SUB: begin
              if (!x_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                if (op == OP_LDA)      acc_next = dat_q;
                else if (op == OP_ADD) acc_next = acc + dat_q;
                else                   acc_next = acc - dat_q;
                pc_next = pc + 1'b1;
              end
            end
            OP_LDI: begin
              if (!x_ok || !w1_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                acc_next = dat_q;
                pc_next  = pc + 1'b1;
              end
            end
            OP_STA: begin
              if (!x_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                dwe     = 1'b1;
                pc_next = pc + 1'b1;
              end
            end
            OP_STI: begin
              if (!x_ok || !w1_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                dwe     = 1'b1;
                dwa     = word1[DAW-1:0];
                pc_next = pc + 1'b1;
              end
            end
            OP_JMP: pc_next = PW'(x);
            OP_JMZ: pc_next = (acc == 32'd0) ? PW'(x) : pc + 1'b1;
            OP_JMN: pc_next = acc[31] ? PW'(x) : pc + 1'b1;
            OP_JAL: begin
              if (x != 10'd0) begin
                if (!x_ok || !tgt_ok) begin
                  err = ERR_BAD_ADDR;
                end else if (32'(sp) >= 32'(STACK_DEPTH)) begin
                  err = ERR_STK_OVER;
                end else begin
                  swe     = 1'b1;
                  sp_next = sp + 1'b1;
                  pc_next = PW'(dat_q - 32'd1);
                end
              end else if (sp == '0) begin
                err = ERR_STK_EMPTY;
              end else begin
                sp_next = sp - 1'b1;
                pc_next = stk_q + 1'b1;
              end
            end
            OP_ALC: begin
              if (!x_ok) begin
                err = ERR_BAD_ADDR;
              end else if (len32 >= 32'(DATA_DEPTH)) begin
                err = ERR_STORE;
              end else begin
                acc_next  = len32;
                dwe       = 1'b1;
                dwa       = DAW'(dlen);
                dwd       = dat_q;
                dlen_next = dlen + 1'b1;
                pc_next   = pc + 1'b1;
              end
            end
            OP_DLC: begin
              if (dlen == '0) begin
                err = ERR_STORE;
              end else if (!x_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                dwe       = 1'b1;
                dwd       = dat_q;
                dlen_next = dlen - 1'b1;
                pc_next   = pc + 1'b1;
              end
            end
            OP_SYS: begin
              if ((acc == 32'd0 || acc == 32'd1) && !x_ok) begin
                err = ERR_BAD_ADDR;
              end else begin
                if (acc == 32'd0) begin
                  kind = KIND_STRING;
                  oval = {22'b0, x};
                end else if (acc == 32'd1) begin
                  kind = KIND_NUMBER;
                  oval = dat_q;
                end
                pc_next = pc + 1'b1;
              end
            end
            OP_HLT: begin
              halt_next = 1'b1;
              pc_next   = plen;
            end
            default: pc_next = pc + 1'b1;
          endcase
          if (err != ERR_NONE) halt_next = 1'b1;
        end
      end
      CMD_READ: begin
        if (adr_ok) begin
          kind = KIND_NUMBER;
          oval = dat_q;
        end else begin
          err = ERR_BAD_ADDR;
        end
      end
      CMD_RESTART: begin
        pc_next   = '0;
        acc_next  = 32'd0;
        sp_next   = '0;
        halt_next = 1'b0;
      end
      default: ;
    endcase
    // writes only land on the commit cycle
    if (!cmd.commit) begin
      dwe = 1'b0;
      pwe = 1'b0;
      swe = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      dlen <= '0;
      pc   <= '0;
      acc  <= 32'd0;
      sp   <= '0;
      halt <= 1'b0;
    end else if (cmd.commit) begin
      plen <= plen_next;
      dlen <= dlen_next;
      pc   <= pc_next;
      acc  <= acc_next;
      sp   <= sp_next;
      halt <= halt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  logic [31:0] pc_next32;
  assign pc_next32 = 32'(pc_next);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.prog_counter <= pc_next32[10:0];
      rsp.accumulator  <= acc_next;
      rsp.halted       <= halt_next;
      rsp.out_kind     <= kind;
      rsp.out_value    <= oval;
      rsp.error        <= err;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for accumulator_machine_core: directed and random command words
// are checked against an in-bench machine model. Depends on amc_pkg, amc_if, the core RTL.
`timescale 1ns / 100ps
module tb_top
  import amc_pkg::*;
();

  typedef struct packed {
    logic [10:0] pc;
    logic [31:0] acc;
    logic        halted;
    logic [1:0]  kind;
    logic [31:0] outv;
    logic [2:0]  err;
  } rsp_word_t;

  // Machine model plus the queue of responses it has predicted.
  class amc_scoreboard;
    logic [13:0] prog_mem [PROG_DEPTH_DEF];
    logic [31:0] data_mem [DATA_DEPTH_DEF];
    logic [9:0]  ret_stack [STACK_DEPTH_DEF];
    int unsigned plen, dlen, pc, depth;
    logic [31:0] acc;
    bit          halt;
    logic [1:0]  kind;
    logic [31:0] outv;
    logic [2:0]  err;
    rsp_word_t   expected_words [$];
    int unsigned fails;

    function new();
      plen = 0; dlen = 0; pc = 0; depth = 0; acc = '0; halt = 0; fails = 0;
    endfunction

    function void fault(logic [2:0] code);
      err  = code;
      halt = 1;
    endfunction

    function bit bad_index(logic [31:0] x);
      if (x >= dlen) begin
        fault(ERR_BAD_ADDR);
        return 1;
      end
      return 0;
    endfunction

    function void run_instr();
      logic [3:0]  op;
      logic [9:0]  x;
      logic [31:0] j;
      longint      tgt;
      if (halt) return;
      if (pc >= plen || pc >= PROG_DEPTH_DEF) begin
        halt = 1;
        return;
      end
      op = prog_mem[pc][13:10];
      x  = prog_mem[pc][9:0];
      case (op)
        OP_LDA, OP_ADD, OP_SUB: begin
          if (bad_index(32'(x))) return;
          if (op == OP_LDA) acc = data_mem[x];
          else if (op == OP_ADD) acc = acc + data_mem[x];
          else acc = acc - data_mem[x];
          pc++;
        end
        OP_LDI, OP_STI: begin
          if (bad_index(32'(x))) return;
          j = data_mem[x];
          if (bad_index(j)) return;
          if (op == OP_LDI) acc = data_mem[j];
          else data_mem[j] = acc;
          pc++;
        end
        OP_STA: begin
          if (bad_index(32'(x))) return;
          data_mem[x] = acc;
          pc++;
        end
        OP_JMP: pc = 32'(x);
        OP_JMZ: pc = (acc == 0) ? 32'(x) : pc + 1;
        OP_JMN: pc = acc[31] ? 32'(x) : pc + 1;
        OP_JAL: begin
          if (x != 0) begin
            if (bad_index(32'(x))) return;
            tgt = longint'($signed(data_mem[x])) - 1;
            if (tgt < 0 || tgt >= PROG_DEPTH_DEF) begin
              fault(ERR_BAD_ADDR);
              return;
            end
            if (depth >= STACK_DEPTH_DEF) begin
              fault(ERR_STK_OVER);
              return;
            end
            ret_stack[depth] = pc[9:0];
            depth++;
            pc = 32'(tgt[10:0]);
          end else begin
            if (depth == 0) begin
              fault(ERR_STK_EMPTY);
              return;
            end
            depth--;
            pc = 32'(ret_stack[depth]) + 1;
          end
        end
        OP_ALC: begin
          if (bad_index(32'(x))) return;
          if (dlen >= DATA_DEPTH_DEF) begin
            fault(ERR_STORE);
            return;
          end
          acc = dlen;
          data_mem[dlen] = data_mem[x];
          dlen++;
          pc++;
        end
        OP_DLC: begin
          if (dlen == 0) begin
            fault(ERR_STORE);
            return;
          end
          if (bad_index(32'(x))) return;
          data_mem[x] = data_mem[dlen-1];
          dlen--;
          pc++;
        end
        OP_SYS: begin
          if (acc == 0) begin
            if (bad_index(32'(x))) return;
            kind = KIND_STRING;
            outv = 32'(x);
          end else if (acc == 1) begin
            if (bad_index(32'(x))) return;
            kind = KIND_NUMBER;
            outv = data_mem[x];
          end
          pc++;
        end
        OP_HLT: begin
          halt = 1;
          pc   = plen;
        end
        default: pc++;
      endcase
    endfunction

    function void note_request(logic [2:0] cmd, logic [3:0] opc, logic [9:0] opd,
                               logic [31:0] val, logic [9:0] adr);
      rsp_word_t w;
      kind = KIND_NONE; outv = '0; err = ERR_NONE;
      case (cmd)
        CMD_PROG: begin
          if (plen >= PROG_DEPTH_DEF) err = ERR_PROG_FULL;
          else prog_mem[plen++] = {opc, opd};
        end
        CMD_DATA: begin
          if (dlen >= DATA_DEPTH_DEF) err = ERR_STORE;
          else data_mem[dlen++] = val;
        end
        CMD_STEP: run_instr();
        CMD_READ: begin
          if (adr < dlen) begin
            kind = KIND_NUMBER;
            outv = data_mem[adr];
          end else begin
            err = ERR_BAD_ADDR;
          end
        end
        CMD_RESTART: begin
          pc = 0; acc = '0; depth = 0; halt = 0;
        end
        default: ;
      endcase
      w = '{pc[10:0], acc, halt, kind, outv, err};
      expected_words = {expected_words, w};
    endfunction

    function void check_response(rsp_word_t got);
      rsp_word_t exp;
      if (expected_words.size() == 0) begin
        $error("response word with none outstanding");
        fails++;
        return;
      end
      exp = expected_words.pop_front();
      if (got.pc !== exp.pc) begin
        $error("prog_counter expected %0d actual %0d", exp.pc, got.pc); fails++;
      end
      if (got.acc !== exp.acc) begin
        $error("accumulator expected %0h actual %0h", exp.acc, got.acc); fails++;
      end
      if (got.halted !== exp.halted) begin
        $error("halted expected %0d actual %0d", exp.halted, got.halted); fails++;
      end
      if (got.kind !== exp.kind) begin
        $error("out_kind expected %0d actual %0d", exp.kind, got.kind); fails++;
      end
      if (got.outv !== exp.outv) begin
        $error("out_value expected %0h actual %0h", exp.outv, got.outv); fails++;
      end
      if (got.err !== exp.err) begin
        $error("error expected %0d actual %0d", exp.err, got.err); fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  amc_req_if req();
  amc_rsp_if rsp();
  amc_scoreboard sb;
  bit quiet;          // phase with no idling on either side
  int words_sent;

  accumulator_machine_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  // Monitor: the response is checked before the request of the same edge is
  // noted, since a response always belongs to an earlier word.
  always @(posedge clk) begin
    if (!rst && sb != null) begin
      if (rsp.valid && rsp.ready)
        sb.check_response('{rsp.prog_counter, rsp.accumulator, rsp.halted,
                            rsp.out_kind, rsp.out_value, rsp.error});
      if (req.valid && req.ready)
        sb.note_request(req.cmd, req.opcode, req.operand, req.value, req.address);
    end
  end

  // Response side: random stall drawn per word.
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = idle_gap();
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
    end
  end

  // One request word; valid stays high across back-to-back words.
  task automatic send_word(input logic [2:0] c, input logic [3:0] o, input logic [9:0] x,
                           input logic [31:0] v, input logic [9:0] a);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid   <= 1'b1;
    req.cmd     <= c;
    req.opcode  <= o;
    req.operand <= x;
    req.value   <= v;
    req.address <= a;
    do @(posedge clk); while (!req.ready);
    words_sent++;
  endtask

  // One extra edge so the monitor has noted the last accepted word.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(int unsigned base, int unsigned n,
                                             int unsigned dl);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, dl + 3);
      2, 3: return base + 1 + $urandom_range(0, n);  // call into the phase's code
      4: return $urandom_range(0, 1);
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0;
        endcase
      end
    endcase
  endfunction

  // Random program word aimed at the current data and code region.
  task automatic send_code(int unsigned base, int unsigned n, int unsigned dl);
    logic [3:0] op;
    logic [9:0] x;
    op = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 7) == 0) x = 10'($urandom_range(0, 1023));
    else if (op == OP_JMP || op == OP_JMZ || op == OP_JMN)
      x = 10'(base + $urandom_range(0, n + 1));
    else if (op == OP_JAL && $urandom_range(0, 2) == 0) x = '0;
    else x = 10'($urandom_range(0, dl + 1));
    send_word(CMD_PROG, op, x, '0, '0);
  endtask

  task automatic send_step_or_read(int unsigned dl);
    int r;
    r = $urandom_range(0, 11);
    if (r < 2)
      send_word(CMD_READ, '0, '0, '0, (r == 0) ? 10'($urandom) : 10'($urandom_range(0, dl + 2)));
    else if (r == 2 && $urandom_range(0, 3) == 0)
      send_word(3'($urandom_range(5, 7)), 4'($urandom), 10'($urandom), $urandom, 10'($urandom));
    else
      send_word(CMD_STEP, '0, '0, '0, '0);
  endtask

  initial begin
    int unsigned p0, d0, base, n, steps;
    sb = new();
    words_sent = 0;
    quiet = 0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.cmd <= CMD_STEP; req.opcode <= OP_LDA; req.operand <= '0;
    req.value <= '0; req.address <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: program end on empty store, DLC on empty data store, then a
    // trampoline at 0..3 (DLC, ALC, STA 4, JAL 4) that lands at data length - 2,
    // followed by wrap-around arithmetic, an indirect load and halt.
    send_word(CMD_STEP, '0, '0, '0, '0);
    send_word(CMD_PROG, OP_DLC, 10'd0, '0, '0);
    send_word(CMD_RESTART, '0, '0, '0, '0);
    send_word(CMD_STEP, '0, '0, '0, '0);
    send_word(CMD_DATA, '0, '0, 32'h7fff_ffff, '0);
    send_word(CMD_DATA, '0, '0, 32'h8000_0000, '0);
    send_word(CMD_DATA, '0, '0, 32'd1, '0);
    send_word(CMD_DATA, '0, '0, 32'd0, '0);
    send_word(CMD_DATA, '0, '0, 32'd0, '0);
    send_word(CMD_DATA, '0, '0, 32'd5, '0);
    send_word(CMD_PROG, OP_ALC, 10'd0, '0, '0);
    send_word(CMD_PROG, OP_STA, 10'd4, '0, '0);
    send_word(CMD_PROG, OP_JAL, 10'd4, '0, '0);
    send_word(CMD_PROG, OP_LDA, 10'd1, '0, '0);
    send_word(CMD_PROG, OP_SUB, 10'd2, '0, '0);
    send_word(CMD_PROG, OP_LDI, 10'd3, '0, '0);
    send_word(CMD_PROG, OP_HLT, 10'd1023, '0, '0);
    send_word(CMD_RESTART, '0, '0, '0, '0);
    repeat (8) send_word(CMD_STEP, '0, '0, '0, '0);
    send_word(CMD_READ, '0, '0, '0, 10'd1023);
    send_word(3'd7, 4'd15, 10'd1023, 32'hffff_ffff, 10'd1023);

    // Random phases: each one drains the core, then either sends noise words or
    // pads so the trampoline lands on fresh code, appends that code, restarts and steps through it.
    while (words_sent < 750) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      p0 = sb.plen;
      d0 = sb.dlen;
      n = $urandom_range(2, 12);
      if (p0 + n > 960 || d0 > 960) break;
      if ($urandom_range(0, 6) == 0) begin
        // noise: any command, any field value
        repeat (8)
          send_word(3'($urandom), 4'($urandom), 10'($urandom), $urandom, 10'($urandom));
        continue;
      end
      if (d0 < p0 + 2) begin
        base = p0;
        repeat (p0 + 2 - d0) send_word(CMD_DATA, '0, '0, pick_value(base, n, d0), '0);
      end else begin
        base = d0 - 2;
        repeat (d0 - 2 - p0) send_word(CMD_PROG, 4'($urandom_range(14, 15)), 10'($urandom),
                                       '0, '0);
      end
      repeat (n) send_code(base, n, base + 2);
      send_word(CMD_RESTART, '0, '0, '0, '0);
      steps = 4 + n + $urandom_range(0, 8);
      repeat (steps) send_step_or_read(base + 2);
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.expected_words.size() == 0) begin
      $display("PASS accumulator_machine_core");
    end else begin
      $display("FAIL accumulator_machine_core");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL accumulator_machine_core");
    $finish;
  end

endmodule
